// File: rtl/bf3_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the 3x3 box filter with edge copy.
// Used by the front, queue, back, top level and the testbench; depends on nothing else.
package bf3_pkg;

   localparam int CH_W       = 8;     // bits per color channel
   localparam int NCH        = 3;     // channels per pixel
   localparam int PIX_W      = CH_W * NCH;
   localparam int ROW_W      = 12;
   localparam int COL_W      = 11;
   localparam int CFG_W      = 12;
   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 4096;
   localparam int WIN_COLS   = 6;     // two previous columns of three rows

   localparam logic [CFG_W-1:0] MIN_DIM      = 12'd3;
   localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd1280;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd720;

   // Nine-pixel sum plus rounding bias stays below 2^12.
   localparam int SUM_W   = 12;
   localparam logic [SUM_W-1:0] ROUND_BIAS = 12'd4;
   // floor(x / 9) == (x * 3641) >> 15 for every x below 4096.
   localparam int RECIP_W   = 12;
   localparam logic [RECIP_W-1:0] RECIP_9 = 12'd3641;
   localparam int DIV_SHIFT = 15;
   localparam int PROD_W    = SUM_W + RECIP_W;

   // Result queue between the front and the back.
   localparam int QDEPTH = 8;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Register index taken from the byte address.
   typedef enum logic {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_index_type;

   // Channel 0 sits in the lowest bits.
   typedef logic [NCH-1:0][CH_W-1:0] pix_type;

   // One queued item: the results one input pixel causes.
   typedef struct packed {
      logic               has_int;  // interior result of (row-1, col-1)
      logic               has_brd;  // border copy of (row, col)
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
      pix_type            filt;
      pix_type            cur;
   } rec_type;

endpackage

// File: rtl/bf3_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.
module bf3_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/bf3_front.sv
`timescale 1ns / 1ps
// Front of the filter: position counters, border/interior classification,
// line stores, 3x3 window, sum and divide by nine. Uses bf3_pkg and bf3_ram.
module bf3_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_accept,
   input  bf3_pkg::pix_type            in_pix,
   input  logic [bf3_pkg::CFG_W-1:0]   eff_width,
   input  logic [bf3_pkg::CFG_W-1:0]   eff_height,
   output logic [1:0]                  inflight,
   output logic                        push_valid,
   output bf3_pkg::rec_type            push_rec
);

   // Position counters.
   logic [bf3_pkg::ROW_W-1:0] row_ff, row_in;
   logic [bf3_pkg::COL_W-1:0] col_ff, col_in;

   logic [bf3_pkg::CFG_W-1:0] col_ext, col_plus;
   logic [bf3_pkg::ROW_W:0]   row_plus;
   logic                      is_int, is_brd;

   always_comb begin
      col_ext  = bf3_pkg::CFG_W'(col_ff);
      col_plus = col_ext + 1'b1;
      row_plus = {1'b0, row_ff} + 1'b1;
      is_int   = (row_ff >= 12'd2) && (col_ff >= 11'd2) &&
                 (row_ff < eff_height) && (col_ext < eff_width);
      is_brd   = (row_ff == '0) || (col_ff == '0) ||
                 (row_plus >= {1'b0, eff_height}) || (col_plus >= eff_width);
      row_in   = row_ff;
      col_in   = col_ff;
      if (in_accept) begin
         if (col_plus >= eff_width) begin
            col_in = '0;
            row_in = (row_plus >= {1'b0, eff_height}) ? '0 :
                     row_plus[bf3_pkg::ROW_W-1:0];
         end else begin
            col_in = col_plus[bf3_pkg::COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // Stage 1: line store data arrives, window shifts, stores are updated.
   logic                      s1_valid_ff, s1_int_ff, s1_brd_ff, s1_ge1_ff, s1_ge2_ff;
   logic [bf3_pkg::ROW_W-1:0] s1_row_ff;
   logic [bf3_pkg::COL_W-1:0] s1_col_ff;
   bf3_pkg::pix_type          s1_cur_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_accept;
      end
      if (in_accept) begin
         s1_row_ff <= row_ff;
         s1_col_ff <= col_ff;
         s1_cur_ff <= in_pix;
         s1_int_ff <= is_int;
         s1_brd_ff <= is_brd;
         s1_ge1_ff <= (row_ff >= 12'd1);
         s1_ge2_ff <= (row_ff >= 12'd2);
      end
   end

   bf3_pkg::pix_type upper_rd, middle_rd, up_pix, mid_pix;

   // Both stores are read at the incoming column; they are written when the read
   // data is back, so the next item's read never collides.
   bf3_ram #(.WIDTH(bf3_pkg::PIX_W), .DEPTH(bf3_pkg::MAX_WIDTH)) u_upper (
      .clock   (clock),
      .wr_en   (s1_valid_ff && s1_ge1_ff),
      .wr_addr (s1_col_ff),
      .wr_data (mid_pix),
      .rd_en   (in_accept),
      .rd_addr (col_ff),
      .rd_data (upper_rd)
   );

   bf3_ram #(.WIDTH(bf3_pkg::PIX_W), .DEPTH(bf3_pkg::MAX_WIDTH)) u_middle (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (s1_cur_ff),
      .rd_en   (in_accept),
      .rd_addr (col_ff),
      .rd_data (middle_rd)
   );

   // Rows above the frame's top read as zero.
   assign up_pix  = s1_ge2_ff ? upper_rd  : '0;
   assign mid_pix = s1_ge1_ff ? middle_rd : '0;

   bf3_pkg::pix_type win_ff [bf3_pkg::WIN_COLS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bf3_pkg::WIN_COLS; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_valid_ff) begin
         win_ff[3] <= win_ff[0];
         win_ff[4] <= win_ff[1];
         win_ff[5] <= win_ff[2];
         win_ff[0] <= up_pix;
         win_ff[1] <= mid_pix;
         win_ff[2] <= s1_cur_ff;
      end
   end

   logic [bf3_pkg::SUM_W-1:0] sum_in [bf3_pkg::NCH];

   always_comb begin
      for (int k = 0; k < bf3_pkg::NCH; k++) begin
         sum_in[k] = bf3_pkg::SUM_W'(up_pix[k]) + bf3_pkg::SUM_W'(mid_pix[k]) +
                     bf3_pkg::SUM_W'(s1_cur_ff[k]) +
                     bf3_pkg::SUM_W'(win_ff[0][k]) + bf3_pkg::SUM_W'(win_ff[1][k]) +
                     bf3_pkg::SUM_W'(win_ff[2][k]) + bf3_pkg::SUM_W'(win_ff[3][k]) +
                     bf3_pkg::SUM_W'(win_ff[4][k]) + bf3_pkg::SUM_W'(win_ff[5][k]) +
                     bf3_pkg::ROUND_BIAS;
      end
   end

   // Stage 2: rounded sums are registered, then divided by nine on the way
   // into the queue.
   logic                      s2_valid_ff, s2_int_ff, s2_brd_ff;
   logic [bf3_pkg::ROW_W-1:0] s2_row_ff;
   logic [bf3_pkg::COL_W-1:0] s2_col_ff;
   bf3_pkg::pix_type          s2_cur_ff;
   logic [bf3_pkg::SUM_W-1:0] s2_sum_ff [bf3_pkg::NCH];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s1_valid_ff) begin
         s2_row_ff <= s1_row_ff;
         s2_col_ff <= s1_col_ff;
         s2_cur_ff <= s1_cur_ff;
         s2_int_ff <= s1_int_ff;
         s2_brd_ff <= s1_brd_ff;
         for (int k = 0; k < bf3_pkg::NCH; k++) begin
            s2_sum_ff[k] <= sum_in[k];
         end
      end
   end

   logic [bf3_pkg::PROD_W-1:0] prod [bf3_pkg::NCH];

   always_comb begin
      for (int k = 0; k < bf3_pkg::NCH; k++) begin
         prod[k] = bf3_pkg::PROD_W'(s2_sum_ff[k]) * bf3_pkg::PROD_W'(bf3_pkg::RECIP_9);
         push_rec.filt[k] = prod[k][bf3_pkg::DIV_SHIFT +: bf3_pkg::CH_W];
      end
      push_rec.has_int = s2_int_ff;
      push_rec.has_brd = s2_brd_ff;
      push_rec.row     = s2_row_ff;
      push_rec.col     = s2_col_ff;
      push_rec.cur     = s2_cur_ff;
   end

   // A pixel that causes no result is dropped here.
   assign push_valid = s2_valid_ff && (s2_int_ff || s2_brd_ff);
   assign inflight   = {1'b0, s1_valid_ff} + {1'b0, s2_valid_ff};

endmodule

// File: rtl/bf3_queue.sv
`timescale 1ns / 1ps
// Short item queue between the front and the back of the filter.
// Uses bf3_pkg for the record type and depth.
module bf3_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_valid,
   input  bf3_pkg::rec_type             push_rec,
   input  logic                         pop,
   output logic                         head_valid,
   output bf3_pkg::rec_type             head_rec,
   output logic [bf3_pkg::QCNT_W-1:0]   count
);

   bf3_pkg::rec_type            entry_ff [bf3_pkg::QDEPTH];
   logic [bf3_pkg::QPTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [bf3_pkg::QCNT_W-1:0]  count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      priority case ({push_valid, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_rec   = entry_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

// File: rtl/bf3_back.sv
`timescale 1ns / 1ps
// Back of the filter: turns each queued item into one or two results and
// drives the output register. Uses bf3_pkg.
module bf3_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        head_valid,
   input  bf3_pkg::rec_type            head_rec,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [bf3_pkg::ROW_W-1:0]   rsp_row,
   output logic [bf3_pkg::COL_W-1:0]   rsp_col,
   output bf3_pkg::pix_type            rsp_pix,
   output logic                        rsp_last
);

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic [bf3_pkg::ROW_W-1:0] rsp_row_ff, rsp_row_in;
   logic [bf3_pkg::COL_W-1:0] rsp_col_ff, rsp_col_in;
   bf3_pkg::pix_type          rsp_pix_ff, rsp_pix_in;
   // Set while the head item's border copy is still to be sent.
   logic                      second_ff, second_in;
   logic                      out_free;

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_pix_in   = rsp_pix_ff;
      second_in    = second_ff;
      pop          = 1'b0;
      if (out_free) begin
         priority if (second_ff) begin
            rsp_valid_in = 1'b1;
            rsp_row_in   = head_rec.row;
            rsp_col_in   = head_rec.col;
            rsp_pix_in   = head_rec.cur;
            rsp_last_in  = 1'b1;
            second_in    = 1'b0;
            pop          = 1'b1;
         end else if (head_valid && head_rec.has_int) begin
            // The window is centered one row up and one column left.
            rsp_valid_in = 1'b1;
            rsp_row_in   = head_rec.row - 1'b1;
            rsp_col_in   = head_rec.col - 1'b1;
            rsp_pix_in   = head_rec.filt;
            rsp_last_in  = !head_rec.has_brd;
            second_in    = head_rec.has_brd;
            pop          = !head_rec.has_brd;
         end else if (head_valid) begin
            rsp_valid_in = 1'b1;
            rsp_row_in   = head_rec.row;
            rsp_col_in   = head_rec.col;
            rsp_pix_in   = head_rec.cur;
            rsp_last_in  = 1'b1;
            pop          = 1'b1;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         second_ff    <= second_in;
      end
      rsp_last_ff <= rsp_last_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_pix_ff  <= rsp_pix_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_row   = rsp_row_ff;
   assign rsp_col   = rsp_col_ff;
   assign rsp_pix   = rsp_pix_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

// File: rtl/box_filter_3x3_edge_copy_top.sv
`timescale 1ns / 1ps
// Top level of the 3x3 box filter with edge copy: register port, front,
// queue and back. Uses bf3_pkg, bf3_front, bf3_queue and bf3_back.
//
// Pixels enter in raster order on the req_ stream, one item per pixel with
// channel 0 in the lowest byte. Each item causes zero, one or two results on
// the rsp_ stream: first the 3x3 mean of the pixel one row up and one column
// left once its window is complete, then a plain copy of the incoming pixel
// if it lies on the frame border. tlast marks the last result of an item.
// Frame size is set through the csr_ port (width at 0x0, height at 0x4); the
// user must write it only while the block is idle, which the block does not enforce.
// An accepted item passes the stage 1 and 2 registers and the queue into the
// output register. An item is accepted every cycle while each causes at most
// one result and the receiver is ready; an item with two results sends them in
// turn on the single result channel. The front pipeline cannot stall; req_tready
// drops once the eight-entry queue plus the items still in the front would be
// full. When the receiver stalls, results wait in the output register and queue.
// Reset clears the position counters, window and queue and restores the
// register defaults; line stores need no clearing pass, since a row is read
// only after the row before wrote it.
module box_filter_3x3_edge_copy_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata,   // chan0_in, chan1_in, chan2_in
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [47:0]                   rsp_tdata,   // out_row, out_col, chan0_out,
                                                      // chan1_out, chan2_out, zero pad
   output logic                          rsp_tlast,   // run_last
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [2:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   logic [bf3_pkg::CFG_W-1:0] width_ff, height_ff, eff_width, eff_height;
   bf3_pkg::reg_index_type    reg_sel;
   logic                      csr_write;

   assign csr_pready = 1'b1;
   assign reg_sel    = bf3_pkg::reg_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bf3_pkg::WIDTH_RESET;
         height_ff <= bf3_pkg::HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (reg_sel)
            bf3_pkg::REG_WIDTH:  width_ff  <= csr_pwdata[bf3_pkg::CFG_W-1:0];
            bf3_pkg::REG_HEIGHT: height_ff <= csr_pwdata[bf3_pkg::CFG_W-1:0];
            default:             width_ff  <= width_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         bf3_pkg::REG_WIDTH:  csr_prdata = 32'(width_ff);
         bf3_pkg::REG_HEIGHT: csr_prdata = 32'(height_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // Out-of-range sizes are clamped; a 12-bit height never reaches the
   // maximum height, so only the lower bound applies there.
   always_comb begin
      if (width_ff < bf3_pkg::MIN_DIM) begin
         eff_width = bf3_pkg::MIN_DIM;
      end else if (width_ff > bf3_pkg::CFG_W'(bf3_pkg::MAX_WIDTH)) begin
         eff_width = bf3_pkg::CFG_W'(bf3_pkg::MAX_WIDTH);
      end else begin
         eff_width = width_ff;
      end
      eff_height = (height_ff < bf3_pkg::MIN_DIM) ? bf3_pkg::MIN_DIM : height_ff;
   end

   logic                       in_accept, push_valid, pop, head_valid;
   logic [1:0]                 inflight;
   logic [bf3_pkg::QCNT_W-1:0] q_count;
   logic [bf3_pkg::QCNT_W:0]   reserved;
   bf3_pkg::rec_type           push_rec, head_rec;
   bf3_pkg::pix_type           rsp_pix;
   logic [bf3_pkg::ROW_W-1:0]  rsp_row;
   logic [bf3_pkg::COL_W-1:0]  rsp_col;

   // Every item in the front holds a queue slot, so the front never stalls.
   assign reserved   = (bf3_pkg::QCNT_W+1)'(q_count) + (bf3_pkg::QCNT_W+1)'(inflight);
   assign req_tready = (reserved < (bf3_pkg::QCNT_W+1)'(bf3_pkg::QDEPTH));
   assign in_accept  = req_tvalid && req_tready;

   bf3_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_accept  (in_accept),
      .in_pix     (bf3_pkg::pix_type'(req_tdata)),
      .eff_width  (eff_width),
      .eff_height (eff_height),
      .inflight   (inflight),
      .push_valid (push_valid),
      .push_rec   (push_rec)
   );

   bf3_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_rec   (push_rec),
      .pop        (pop),
      .head_valid (head_valid),
      .head_rec   (head_rec),
      .count      (q_count)
   );

   bf3_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_rec   (head_rec),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_row    (rsp_row),
      .rsp_col    (rsp_col),
      .rsp_pix    (rsp_pix),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, rsp_pix, rsp_col, rsp_row};

endmodule

// File: rtl/bf3_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the box filter's result stream, bound to the top level.
// Depends only on the top level's ports.
module bf3_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   input  logic        rsp_tlast
);

   // A stalled result holds still.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Nothing is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // A first of two results is an interior pixel, never on row or column zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (rsp_tdata[11:0] != 12'd0) && (rsp_tdata[22:12] != 11'd0))
      else $error("interior result at frame edge");

   // The border copy follows its interior result at once, one row down and
   // one column right.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid &&
         (rsp_tdata[11:0] == $past(rsp_tdata[11:0]) + 12'd1) &&
         (rsp_tdata[22:12] == $past(rsp_tdata[22:12]) + 11'd1))
      else $error("second result missing or misplaced");

endmodule

bind box_filter_3x3_edge_copy_top bf3_checker u_bf3_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// File: tb/box_mean_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the 3x3 box filter with edge copy: follows the csr_ writes,
// predicts the results of every accepted item and checks the rsp_ stream.
// Depends on bf3_pkg for widths, register indexes and the pixel type.
module box_mean_checker
   import bf3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // chan0_in, chan1_in, chan2_in
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,   // out_row, out_col, chan0_out, chan1_out, chan2_out
   input  logic        rsp_tlast,   // run_last
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mismatch_count,
   output int          pending_results
);

   localparam int WINDOW_TAPS = 9;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      pix_type          pix;
      logic             last;
   } mean_result_type;

   pix_type          upper_store  [MAX_WIDTH];
   pix_type          middle_store [MAX_WIDTH];
   pix_type          window       [WIN_COLS];
   int               row_pos;
   int               col_pos;
   logic [CFG_W-1:0] width_reg;
   logic [CFG_W-1:0] height_reg;
   mean_result_type  expected_pixels [$];
   int               errors;

   function automatic int width_used(input logic [CFG_W-1:0] raw);
      int w;
      w = int'(raw);
      if (w < int'(MIN_DIM)) w = int'(MIN_DIM);
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
   endfunction

   function automatic int height_used(input logic [CFG_W-1:0] raw);
      int h;
      h = int'(raw);
      if (h < int'(MIN_DIM)) h = int'(MIN_DIM);
      return h;
   endfunction

   task automatic predict_pixel(input pix_type px);
      int              w, h, r, c, k, e, sum;
      logic            is_interior, is_border;
      pix_type         up, mid, mean;
      mean_result_type item;
      w = width_used(width_reg);
      h = height_used(height_reg);
      r = row_pos;
      c = col_pos;
      up = '0;
      mid = '0;
      if (r >= 2) up = upper_store[c];
      if (r >= 1) mid = middle_store[c];
      mean = '0;
      is_interior = (r >= 2) && (c >= 2) && (r < h) && (c < w);
      is_border = (r == 0) || (c == 0) || (r + 1 >= h) || (c + 1 >= w);

      // The mean belongs to the pixel one row up and one column left.
      if (is_interior) begin
         for (k = 0; k < NCH; k++) begin
            sum = int'(up[k]) + int'(mid[k]) + int'(px[k]) + int'(ROUND_BIAS);
            for (e = 0; e < WIN_COLS; e++) sum += int'(window[e][k]);
            mean[k] = CH_W'(sum / WINDOW_TAPS);
         end
         item.row = ROW_W'(r - 1);
         item.col = COL_W'(c - 1);
         item.pix = mean;
         item.last = !is_border;
         expected_pixels.push_back(item);
      end
      if (is_border) begin
         item.row = ROW_W'(r);
         item.col = COL_W'(c);
         item.pix = px;
         item.last = 1'b1;
         expected_pixels.push_back(item);
      end

      if (r >= 1) upper_store[c] = mid;
      middle_store[c] = px;
      window[3] = window[0];
      window[4] = window[1];
      window[5] = window[2];
      window[0] = up;
      window[1] = mid;
      window[2] = px;

      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      row_pos = r;
      col_pos = c;
   endtask

   task automatic check_result();
      mean_result_type want, got;
      got.row = rsp_tdata[ROW_W-1:0];
      got.col = rsp_tdata[ROW_W +: COL_W];
      got.pix = rsp_tdata[ROW_W+COL_W +: PIX_W];
      got.last = rsp_tlast;
      if (expected_pixels.size() == 0) begin
         errors++;
         if (errors <= MAX_REPORTS)
            $display("%0t: result with nothing expected: row %0d col %0d pix %h last %b",
                     $realtime, got.row, got.col, got.pix, got.last);
      end else begin
         want = expected_pixels.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display({"%0t: mismatch: expected row %0d col %0d pix %h last %b,",
                         " got row %0d col %0d pix %h last %b"},
                        $realtime, want.row, want.col, want.pix, want.last,
                        got.row, got.col, got.pix, got.last);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_store[i] = '0;
            middle_store[i] = '0;
         end
         for (int i = 0; i < WIN_COLS; i++) window[i] = '0;
         row_pos = 0;
         col_pos = 0;
         width_reg = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         expected_pixels.delete();
         errors = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[2]))
               REG_WIDTH: begin
                  width_reg = csr_pwdata[CFG_W-1:0];
               end
               REG_HEIGHT: begin
                  height_reg = csr_pwdata[CFG_W-1:0];
               end
            endcase
         end
         if (req_tvalid && req_tready) predict_pixel(req_tdata);
         if (rsp_tvalid && rsp_tready) check_result();
      end
      mismatch_count <= errors;
      pending_results <= expected_pixels.size();
   end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the 3x3 box filter with edge copy: frame sizes,
// pixel bursts and result-side stalls. Uses bf3_pkg, the block's top level
// and box_mean_checker.
module testbench;
   import bf3_pkg::*;

   localparam int LIMIT_CYCLES  = 1_000_000;
   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_ITEMS  = 940;

   typedef enum {ALWAYS_READY, COIN_FLIP, MOSTLY_STALLED, PERIODIC} sink_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int            mismatch_count;
   int            pending_results;
   int            cycle_count = 0;
   int            pixels_sent = 0;
   int            frame_row = 0;
   int            frame_col = 0;
   int            width_set = int'(WIDTH_RESET);
   int            height_set = int'(HEIGHT_RESET);
   int            burst_left = 0;
   logic          steady = 1'b0;
   sink_mode_type sink_mode = ALWAYS_READY;
   int            mode_left = 0;

   always #2 clock = ~clock;

   box_filter_3x3_edge_copy_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   box_mean_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_pready      (csr_pready),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   // The receiver switches between stall patterns, each held for a random stretch.
   always @(negedge clock) begin
      if (mode_left == 0) begin
         sink_mode = sink_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(40, 400);
      end
      mode_left--;
      case (sink_mode)
         ALWAYS_READY: begin
            rsp_tready <= 1'b1;
         end
         COIN_FLIP: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         MOSTLY_STALLED: begin
            rsp_tready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_tready <= (mode_left % 8) < 5;
         end
      endcase
   end

   function automatic int dim_used(input int raw, input int limit);
      if (raw < int'(MIN_DIM)) return int'(MIN_DIM);
      if (raw > limit) return limit;
      return raw;
   endfunction

   function automatic logic [23:0] random_pixel();
      logic [23:0] px;
      int          k;
      px = 24'($urandom);
      for (k = 0; k < NCH; k++) begin
         case ($urandom_range(0, 7))
            0: px[k*CH_W +: CH_W] = '0;
            1: px[k*CH_W +: CH_W] = '1;
            default: ;
         endcase
      end
      return px;
   endfunction

   task automatic send_pixel(input logic [23:0] px);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = steady ? 0 : $urandom_range(0, 5);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= px;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
      // Track the raster position so that widths grow only at a frame start.
      frame_col++;
      if (frame_col >= dim_used(width_set, MAX_WIDTH)) begin
         frame_col = 0;
         frame_row++;
         if (frame_row >= dim_used(height_set, MAX_HEIGHT - 1)) frame_row = 0;
      end
   endtask

   task automatic finish_frame();
      while (frame_row != 0 || frame_col != 0) send_pixel(random_pixel());
   endtask

   // Waits until every expected result is in, plus time for items that
   // cause no result to leave the pipeline.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input int value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= ($urandom & 32'hFFFF_F000) | (value & 32'h0000_0FFF);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == REG_WIDTH) width_set = value & 'hFFF;
      else height_set = value & 'hFFF;
   endtask

   task automatic set_size(input int w, input int h);
      drain();
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
   endtask

   initial begin : stimulus
      int stop_at, w, h, frames;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Default frame size: a few pixels of the first row, then the frame
      // shrinks under the current position, so the next pixel is copied.
      send_pixel(24'hFFFFFF);
      send_pixel(24'hFFFFFF);
      send_pixel(24'hFFFFFF);
      send_pixel(24'h123456);
      send_pixel(24'h00FF00);
      set_size(3, 4);
      send_pixel(24'hA55AA5);
      repeat (6) send_pixel(24'hFFFFFF);
      send_pixel(24'h000000);
      send_pixel(24'h5AA5C3);
      send_pixel(24'h000000);

      // Sizes below the minimum clamp to a 3x3 frame.
      set_size(1, 0);
      repeat (9) send_pixel(24'h000000);

      // A width above the line store clamps to its depth; the first row is
      // then cut short by lowering the width under the current column.
      set_size(4095, 3);
      repeat (6) send_pixel(random_pixel());
      drain();
      write_reg(REG_WIDTH, 4);
      finish_frame();

      // Tallest frame, cut short by lowering the height below the row.
      set_size(3, 4095);
      repeat (3 * 40) send_pixel(random_pixel());
      drain();
      write_reg(REG_HEIGHT, 6);
      finish_frame();

      stop_at = pixels_sent + RANDOM_ITEMS;
      while (pixels_sent < stop_at) begin
         case ($urandom_range(0, 9))
            0: w = $urandom_range(0, 2);
            1: w = $urandom_range(13, 40);
            default: w = $urandom_range(3, 12);
         endcase
         case ($urandom_range(0, 9))
            0: h = $urandom_range(0, 2);
            1: h = $urandom_range(9, 16);
            default: h = $urandom_range(3, 8);
         endcase
         set_size(w, h);
         steady = ($urandom_range(0, 3) == 0);
         frames = $urandom_range(1, 2);
         repeat (frames) begin
            send_pixel(random_pixel());
            finish_frame();
         end
         // Mid-frame change: the width may only shrink, the height may move.
         if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 2 * dim_used(width_set, MAX_WIDTH)))
               send_pixel(random_pixel());
            drain();
            if ($urandom_range(0, 1) == 0)
               write_reg(REG_WIDTH, $urandom_range(0, dim_used(width_set, MAX_WIDTH)));
            else
               write_reg(REG_HEIGHT, $urandom_range(0, 12));
            finish_frame();
         end
      end

      drain();
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

endmodule
